[design/kvt_pkg.sv]
// ----------------------------------------------------------------------------
// kvt_pkg
// shared field widths, opcodes, status codes and scan control for the
// keyed value table
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

  localparam int OPCODE_W    = 2;
  localparam int KEY_FIELD_W = 16;
  localparam int VAL_FIELD_W = 16;
  localparam int STATUS_W    = 3;
  localparam int TALLY_W     = 6;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_COUNT  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

`default_nettype wire

[design/kvt_if.sv]
// ----------------------------------------------------------------------------
// kvt_if
// request and response channels of the keyed value table
// ----------------------------------------------------------------------------
`default_nettype none

interface kvt_req_if;
  logic                                valid;
  logic                                ready;
  logic [kvt_pkg::OPCODE_W-1:0]    opcode;
  logic [kvt_pkg::KEY_FIELD_W-1:0] item_key;
  logic [kvt_pkg::VAL_FIELD_W-1:0] item_value;

  modport source (output valid, opcode, item_key, item_value, input ready);
  modport sink   (input valid, opcode, item_key, item_value, output ready);
endinterface

interface kvt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [kvt_pkg::STATUS_W-1:0] status;
  logic                             found;
  logic [kvt_pkg::TALLY_W-1:0]  match_count;
  logic [kvt_pkg::TALLY_W-1:0]  occupancy;

  modport source (output valid, status, found, match_count, occupancy, input ready);
  modport sink   (input valid, status, found, match_count, occupancy, output ready);
endinterface

`default_nettype wire

[design/kvt_store.sv]
// ----------------------------------------------------------------------------
// kvt_store
// key and value memories, one shared read address, one write port each,
// registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_store #(
  parameter int DEPTH   = 32,
  parameter int ADDR_W  = 5,
  parameter int KEY_W   = 16,
  parameter int VALUE_W = 16
) (
  input  wire logic               clk,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output logic      [KEY_W-1:0]   rd_key,
  output logic      [VALUE_W-1:0] rd_value,
  input  wire logic               key_we,
  input  wire logic               value_we,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire logic [KEY_W-1:0]   wr_key,
  input  wire logic [VALUE_W-1:0] wr_value
);

  logic [KEY_W-1:0]   key_mem   [DEPTH];
  logic [VALUE_W-1:0] value_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[wr_addr] <= wr_value;
    end
    rd_value <= value_mem[rd_addr];
  end

endmodule

`default_nettype wire

[design/kvt_scan.sv]
// ----------------------------------------------------------------------------
// kvt_scan
// walks the read stream of one table sweep: first slot holding the key,
// first empty slot and the tally of occupied slots holding the target value
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_scan #(
  parameter int ADDR_W  = 5,
  parameter int CNT_W   = 6,
  parameter int KEY_W   = 16,
  parameter int VALUE_W = 16
) (
  input  wire logic                  clk,
  input  wire kvt_pkg::scan_ctl_t    ctl,
  input  wire logic [KEY_W-1:0]      target_key,
  input  wire logic [VALUE_W-1:0]    target_value,
  input  wire logic [KEY_W-1:0]      rd_key,
  input  wire logic [VALUE_W-1:0]    rd_value,
  output logic                       hit,
  output logic      [ADDR_W-1:0]     hit_slot,
  output logic                       empty_seen,
  output logic      [ADDR_W-1:0]     empty_slot,
  output logic      [CNT_W-1:0]      tally
);

  logic [ADDR_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      idx        <= '0;
      hit        <= 1'b0;
      empty_seen <= 1'b0;
      tally      <= '0;
    end else if (ctl.sample) begin
      idx <= idx + 1'b1;
      if (!hit && rd_key == target_key) begin
        hit      <= 1'b1;
        hit_slot <= idx;
      end
      if (!empty_seen && rd_key == '0) begin
        empty_seen <= 1'b1;
        empty_slot <= idx;
      end
      if (rd_key != '0 && rd_value == target_value) begin
        tally <= tally + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/keyed_value_table_top.sv]
// ----------------------------------------------------------------------------
// keyed_value_table_top
// fixed-capacity key/value table; key zero marks an empty slot
//
// req carries one word per operation (opcode, item_key, item_value); rsp
// returns one word per operation (status, found, match_count, occupancy).
// Each operation sweeps every slot of the key and value memories through
// their registered read port, passes through a wait state, then decides
// and writes back; its response word is registered at write-back.
// One operation is in flight at a time; req.ready is high only while idle.
// After reset a clearing pass writes zero to every key slot, one slot a
// cycle; req.ready stays low during that pass.
// The response sits in an output register; when rsp stalls, the finished
// operation waits before write-back until the register frees, so at most
// one further operation is taken in while a response is held.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_value_table_top #(
  parameter int CAPACITY    = 32,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  kvt_req_if.sink     req,
  kvt_rsp_if.source   rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (KEY_WIDTH < kvt_pkg::KEY_FIELD_W) ? KEY_WIDTH : kvt_pkg::KEY_FIELD_W;
  localparam int VW = (VALUE_WIDTH < kvt_pkg::VAL_FIELD_W) ? VALUE_WIDTH
                                                            : kvt_pkg::VAL_FIELD_W;
  localparam int OW = (CW > kvt_pkg::TALLY_W) ? CW : kvt_pkg::TALLY_W;

  localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0]                       state;
  logic [2:0]                       state_next;
  logic [AW-1:0]                    addr;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    count_next;
  logic [kvt_pkg::OPCODE_W-1:0]     op;
  logic [KW-1:0]                    key;
  logic [VW-1:0]                    val;
  logic                             sample_d;

  logic                             rsp_valid;
  logic [kvt_pkg::STATUS_W-1:0]     rsp_status;
  logic                             rsp_found;
  logic [kvt_pkg::TALLY_W-1:0]      rsp_match;
  logic [kvt_pkg::TALLY_W-1:0]      rsp_occ;

  logic [KW-1:0]                    rd_key;
  logic [VW-1:0]                    rd_value;
  logic                             key_we;
  logic                             value_we;
  logic [AW-1:0]                    wr_addr;
  logic [KW-1:0]                    wr_key;

  logic                             hit;
  logic [AW-1:0]                    hit_slot;
  logic                             empty_seen;
  logic [AW-1:0]                    empty_slot;
  logic [CW-1:0]                    tally;
  kvt_pkg::scan_ctl_t               scan_ctl;

  logic                             accept;
  logic                             retire;
  logic                             key_zero;
  logic                             found;
  logic [kvt_pkg::STATUS_W-1:0]     status;
  logic                             do_insert;
  logic                             do_remove;
  logic [OW-1:0]                    tally_wide;
  logic [OW-1:0]                    occ_wide;

  assign accept   = req.valid && req.ready;
  assign retire   = (state == S_DECIDE) && (!rsp_valid || rsp.ready);
  assign key_zero = (key == '0);
  assign found    = (op != kvt_pkg::OP_COUNT) && !key_zero && hit;

  always_comb begin
    status    = kvt_pkg::ST_OK;
    do_insert = 1'b0;
    do_remove = 1'b0;
    unique case (op)
      kvt_pkg::OP_INSERT: begin
        priority if (count >= FULL_CNT) begin
          status = kvt_pkg::ST_FULL;
        end else if (key_zero) begin
          status = kvt_pkg::ST_ZERO;
        end else if (found) begin
          status = kvt_pkg::ST_DUP;
        end else if (empty_seen) begin
          do_insert = 1'b1;
        end else begin
          status = kvt_pkg::ST_FULL;
        end
      end
      kvt_pkg::OP_REMOVE: begin
        priority if (key_zero) begin
          status = kvt_pkg::ST_ZERO;
        end else if (!found) begin
          status = kvt_pkg::ST_MISSING;
        end else begin
          do_remove = 1'b1;
        end
      end
      kvt_pkg::OP_LOOKUP: begin
        priority if (key_zero) begin
          status = kvt_pkg::ST_ZERO;
        end else if (!found) begin
          status = kvt_pkg::ST_MISSING;
        end
      end
      kvt_pkg::OP_COUNT: begin
        status = kvt_pkg::ST_OK;
      end
      default: begin
        status = kvt_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + 1'b1;
    end else if (do_remove && count != '0) begin
      count_next = count - 1'b1;
    end
  end

  assign tally_wide = OW'(tally);
  assign occ_wide   = OW'(count_next);

  always_comb begin
    key_we   = 1'b0;
    value_we = 1'b0;
    wr_addr  = addr;
    wr_key   = '0;
    if (state == S_CLEAR) begin
      key_we = 1'b1;
    end else if (retire && do_insert) begin
      key_we   = 1'b1;
      value_we = 1'b1;
      wr_addr  = empty_slot;
      wr_key   = key;
    end else if (retire && do_remove) begin
      key_we  = 1'b1;
      wr_addr = hit_slot;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (addr == LAST_ADDR) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (retire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      count     <= '0;
      sample_d  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      sample_d <= (state == S_SCAN);
      if (state == S_CLEAR || state == S_SCAN) begin
        addr <= (addr == LAST_ADDR) ? '0 : addr + 1'b1;
      end else if (accept) begin
        addr <= '0;
      end
      if (retire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= req.opcode;
      key <= req.item_key[KW-1:0];
      val <= req.item_value[VW-1:0];
    end
    if (retire) begin
      rsp_status <= status;
      rsp_found  <= found;
      rsp_match  <= (op == kvt_pkg::OP_COUNT) ? tally_wide[kvt_pkg::TALLY_W-1:0] : '0;
      rsp_occ    <= occ_wide[kvt_pkg::TALLY_W-1:0];
    end
  end

  assign scan_ctl.clear  = accept;
  assign scan_ctl.sample = sample_d;

  kvt_store #(
    .DEPTH   (CAPACITY),
    .ADDR_W  (AW),
    .KEY_W   (KW),
    .VALUE_W (VW)
  ) u_store (
    .clk      (clk),
    .rd_addr  (addr),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .key_we   (key_we),
    .value_we (value_we),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_value (val)
  );

  kvt_scan #(
    .ADDR_W  (AW),
    .CNT_W   (CW),
    .KEY_W   (KW),
    .VALUE_W (VW)
  ) u_scan (
    .clk          (clk),
    .ctl          (scan_ctl),
    .target_key   (key),
    .target_value (val),
    .rd_key       (rd_key),
    .rd_value     (rd_value),
    .hit          (hit),
    .hit_slot     (hit_slot),
    .empty_seen   (empty_seen),
    .empty_slot   (empty_slot),
    .tally        (tally)
  );

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.found       = rsp_found;
  assign rsp.match_count = rsp_match;
  assign rsp.occupancy   = rsp_occ;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count beyond capacity");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    key_we |-> (state == S_CLEAR || state == S_DECIDE))
    else $error("key memory written outside clear or write-back");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_DECIDE)
    else $error("response word raised without a finished operation");

  a_scan_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> !sample_d || $past(addr) == LAST_ADDR)
    else $error("sweep ended before the last slot");

endmodule

`default_nettype wire

[tb/sv/kvt_table_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// kvt_table_scoreboard_pkg
// predicts and checks the response words of the keyed value table: keeps
// its own copy of the key and value slots, works out one expected response
// per accepted request and compares arriving responses field by field
// ----------------------------------------------------------------------------
package kvt_table_scoreboard_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import kvt_pkg::*;

  localparam int SLOTS = 32;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [TALLY_W-1:0]  match_count;
    logic [TALLY_W-1:0]  occupancy;
  } table_result_t;

  class table_scoreboard;
    logic [KEY_FIELD_W-1:0] slot_key [SLOTS];
    logic [VAL_FIELD_W-1:0] slot_value [SLOTS];
    int unsigned            held;
    table_result_t          awaited[$];
    int unsigned            mismatches;
    int unsigned            operations;
    int unsigned            count_queries;
    int unsigned            peak_held;
    int unsigned            status_hits [5];

    function new();
      foreach (slot_key[i]) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
      end
      foreach (status_hits[i]) status_hits[i] = 0;
      held          = 0;
      mismatches    = 0;
      operations    = 0;
      count_queries = 0;
      peak_held     = 0;
    endfunction

    function table_result_t apply(logic [OPCODE_W-1:0] op, logic [KEY_FIELD_W-1:0] key,
                                  logic [VAL_FIELD_W-1:0] val);
      table_result_t r;
      int            slot;
      int            empty;
      int unsigned   tally;
      r     = '0;
      slot  = SLOTS;
      empty = SLOTS;
      tally = 0;
      if (op != OP_COUNT && key != '0) begin
        for (int i = SLOTS - 1; i >= 0; i--) if (slot_key[i] == key) slot = i;
      end
      r.found  = (slot < SLOTS);
      r.status = ST_OK;
      case (op)
        OP_INSERT: begin
          if (held >= SLOTS) begin
            r.status = ST_FULL;
          end else if (key == '0) begin
            r.status = ST_ZERO;
          end else if (r.found) begin
            r.status = ST_DUP;
          end else begin
            for (int i = SLOTS - 1; i >= 0; i--) if (slot_key[i] == '0) empty = i;
            if (empty < SLOTS) begin
              slot_key[empty]   = key;
              slot_value[empty] = val;
              held++;
            end else begin
              r.status = ST_FULL;
            end
          end
        end
        OP_REMOVE: begin
          if (key == '0) begin
            r.status = ST_ZERO;
          end else if (!r.found) begin
            r.status = ST_MISSING;
          end else begin
            slot_key[slot] = '0;
            if (held > 0) held--;
          end
        end
        OP_LOOKUP: begin
          if (key == '0) r.status = ST_ZERO;
          else if (!r.found) r.status = ST_MISSING;
        end
        default: begin
          foreach (slot_key[i]) if (slot_key[i] != '0 && slot_value[i] == val) tally++;
          r.match_count = tally[TALLY_W-1:0];
        end
      endcase
      r.occupancy = held[TALLY_W-1:0];
      return r;
    endfunction

    function void note_request(logic [OPCODE_W-1:0] op, logic [KEY_FIELD_W-1:0] key,
                               logic [VAL_FIELD_W-1:0] val);
      table_result_t r;
      r = apply(op, key, val);
      awaited.push_back(r);
      operations++;
      if (op == OP_COUNT) count_queries++;
      if (r.status < 5) status_hits[r.status]++;
      if (held > peak_held) peak_held = held;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_response(table_result_t got);
      table_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: response word with nothing awaited, actual %p", $time, got);
      end else begin
        want = awaited.pop_front();
        compare_field("status", 8'(want.status), 8'(got.status));
        compare_field("found", 8'(want.found), 8'(got.found));
        compare_field("match_count", 8'(want.match_count), 8'(got.match_count));
        compare_field("occupancy", 8'(want.occupancy), 8'(got.occupancy));
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

endpackage

[tb/sv/keyed_value_table_top_tb.sv]
// ----------------------------------------------------------------------------
// keyed_value_table_top_tb
// drives insert, remove, lookup and count words into the keyed value table
// under random sender gaps and receiver stalls: a directed opening on the
// zero key, duplicates, missing keys and slot reuse, then random words over
// a small key pool that alternately fill the table past capacity and drain it
// ----------------------------------------------------------------------------
module keyed_value_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kvt_pkg::*;
  import kvt_table_scoreboard_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_WORDS = 134;

  logic        clk;
  logic        rst;
  int          send_idle_pct;
  int          recv_idle_pct;
  int unsigned quiet_cycles;

  logic [KEY_FIELD_W-1:0] key_pool [40];
  logic [VAL_FIELD_W-1:0] value_pool [4];

  table_scoreboard sb = new();

  kvt_req_if req_ch ();
  kvt_rsp_if rsp_ch ();

  keyed_value_table_top #(
    .CAPACITY(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [KEY_FIELD_W-1:0] key,
                           input logic [VAL_FIELD_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.item_key   <= key;
    req_ch.item_value <= val;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(op, key, val);
  endtask

  task automatic wait_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [OPCODE_W-1:0] pick_op(bit fill);
    int r;
    r = $urandom_range(99);
    if (fill) begin
      if (r < 75) return OP_INSERT;
      if (r < 83) return OP_REMOVE;
      if (r < 92) return OP_LOOKUP;
      return OP_COUNT;
    end
    if (r < 15) return OP_INSERT;
    if (r < 65) return OP_REMOVE;
    if (r < 85) return OP_LOOKUP;
    return OP_COUNT;
  endfunction

  function automatic logic [KEY_FIELD_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 90) return key_pool[$urandom_range(39)];
    if (r < 95) return '0;
    return KEY_FIELD_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [VAL_FIELD_W-1:0] pick_value();
    if ($urandom_range(99) < 60) return value_pool[$urandom_range(3)];
    return VAL_FIELD_W'($urandom_range(0, 65535));
  endfunction

  // response side: check on handshake, then draw the next ready
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        sb.check_response({rsp_ch.status, rsp_ch.found, rsp_ch.match_count,
                           rsp_ch.occupancy});
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("keyed_value_table_top_tb failed");
    $finish;
  end

  initial begin
    send_idle_pct = 24;
    recv_idle_pct = 76;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= OP_INSERT;
    req_ch.item_key   <= '0;
    req_ch.item_value <= '0;
    foreach (key_pool[i]) key_pool[i] = KEY_FIELD_W'($urandom_range(1, 65535));
    foreach (value_pool[i]) value_pool[i] = VAL_FIELD_W'($urandom_range(0, 65535));
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        // zero key on every opcode, empty table count
        send_word(OP_LOOKUP, 16'h0000, 16'h0000);
        send_word(OP_REMOVE, 16'h0000, 16'hFFFF);
        send_word(OP_INSERT, 16'h0000, 16'h1234);
        send_word(OP_COUNT,  16'h0000, 16'h0000);
        // extremes, duplicate keeps old value
        send_word(OP_INSERT, 16'hFFFF, 16'hFFFF);
        send_word(OP_INSERT, 16'h0001, 16'h0000);
        send_word(OP_INSERT, 16'h8000, 16'hFFFF);
        send_word(OP_INSERT, 16'hFFFF, 16'h0000);
        send_word(OP_LOOKUP, 16'hFFFF, 16'h0000);
        send_word(OP_LOOKUP, 16'h0001, 16'hFFFF);
        send_word(OP_LOOKUP, 16'h7FFF, 16'h0000);
        send_word(OP_COUNT,  16'hFFFF, 16'hFFFF);
        send_word(OP_COUNT,  16'h0000, 16'h0000);
        // missing keys, removal and slot reuse
        send_word(OP_REMOVE, 16'h7FFF, 16'h0000);
        send_word(OP_REMOVE, 16'hFFFF, 16'h0000);
        send_word(OP_LOOKUP, 16'hFFFF, 16'h0000);
        send_word(OP_REMOVE, 16'hFFFF, 16'h0000);
        send_word(OP_INSERT, 16'hFFFF, 16'h5555);
        send_word(OP_COUNT,  16'h1234, 16'h5555);
        send_word(OP_COUNT,  16'h0000, 16'hFFFF);
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(pick_op(((n / 64) % 2) == 0), pick_key(), pick_value());
        if (n % 50 == 49) wait_until_drained();
      end
      wait_until_drained();
    end

    repeat (SLOTS + 8) @(posedge clk);

    $display("covered %0d words: ok %0d, duplicate %0d, full %0d, zero key %0d, missing %0d",
             sb.operations, sb.status_hits[ST_OK], sb.status_hits[ST_DUP],
             sb.status_hits[ST_FULL], sb.status_hits[ST_ZERO], sb.status_hits[ST_MISSING]);
    $display("peak occupancy %0d of %0d slots, %0d count queries, three idle profiles",
             sb.peak_held, SLOTS, sb.count_queries);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("keyed_value_table_top_tb passed");
    end else begin
      $display("keyed_value_table_top_tb failed");
    end
    $finish;
  end

endmodule
